/* rtl/biq_pkg.sv */
`timescale 1ns / 1ps
// Biquad filter package: word types, widths and register indexes.
package biq_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int CHAN_WIDTH = 3;
   localparam int COEF_WIDTH = 32;
   localparam int COEF_FRAC = 28;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic ACTION_FILTER = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF_B0    = 3'd0,
      CSR_COEF_B1_FF = 3'd1,
      CSR_COEF_B2_FF = 3'd2,
      CSR_COEF_FB1   = 3'd3,
      CSR_COEF_FB2   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                           action;
      logic [CHAN_WIDTH-1:0]          chan;
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0]          chan_out;
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
   } rsp_word_type;

endpackage

/* rtl/multichannel_biquad_filter_top.sv */
`timescale 1ns / 1ps
// Multichannel direct form I biquad: history memory, product pipeline, output register.
// A word accepted passes stage 1, stage 2 and stage 3 to the output register and rsp_valid.
// Throughput: one word per cycle while successive words name different channels and rsp_stall
// holds nothing back; a word for a channel still in the three-stage pipeline waits until its
// history is written back, so one channel alone takes a new word only once its last has left.
// Reset: coefficients and all channel histories read as zero straight away
// (per-channel valid flags, no clearing pass); a clear word waits for an empty pipeline.
module multichannel_biquad_filter_top
   import biq_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
   localparam int ACC_W = PROD_W + 3;
   localparam int SC_W = ACC_W - COEF_FRAC;
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
   localparam logic signed [SC_W-1:0] SAT_HI =
      {{(SC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SC_W-1:0] SAT_LO =
      {{(SC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] x1;
      logic signed [SAMPLE_WIDTH-1:0] x2;
      logic signed [SAMPLE_WIDTH-1:0] y1;
      logic signed [SAMPLE_WIDTH-1:0] y2;
   } hist_entry_type;

   // coefficients
   logic signed [COEF_WIDTH-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_fb1_ff, coef_fb2_ff;

   // history memory and per-channel valid flags
   hist_entry_type hist_mem [CHANNELS];
   logic [CHANNELS-1:0] hist_valid_ff;
   hist_entry_type rd_entry_ff;
   logic rd_valid_ff;

   // stage 1: history read
   logic s1_v_ff;
   logic [CHAN_WIDTH-1:0] s1_chan_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_x_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_x1, s1_x2, s1_y1, s1_y2;

   // stage 2: products
   logic s2_v_ff;
   logic [CHAN_WIDTH-1:0] s2_chan_ff;
   logic signed [SAMPLE_WIDTH-1:0] s2_x_ff, s2_x1_ff, s2_y1_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in, p3_in, p4_in;

   // stage 3: partial sums
   logic s3_v_ff;
   logic [CHAN_WIDTH-1:0] s3_chan_ff;
   logic signed [SAMPLE_WIDTH-1:0] s3_x_ff, s3_x1_ff, s3_y1_ff;
   logic signed [ACC_W-1:0] ff_sum_ff, fb_sum_ff, ff_sum_in, fb_sum_in;

   // final round and saturate
   logic signed [ACC_W-1:0] total;
   logic signed [SC_W-1:0] scaled;
   logic signed [SAMPLE_WIDTH-1:0] y_in;

   // output register
   logic rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   // control
   logic out_free, s3_ready, s2_ready, s1_ready;
   logic in_range, hazard, busy, take_item, take_clear, wb;
   logic [AW-1:0] rd_addr, wr_addr;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s3_ready = !s3_v_ff || out_free;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;

   assign in_range = 32'(req_data.chan) < CHANNELS;
   assign hazard = (s1_v_ff && (s1_chan_ff == req_data.chan)) ||
                   (s2_v_ff && (s2_chan_ff == req_data.chan)) ||
                   (s3_v_ff && (s3_chan_ff == req_data.chan));
   assign busy = s1_v_ff || s2_v_ff || s3_v_ff;

   always_comb begin
      if (req_data.action == ACTION_CLEAR) begin
         req_stall = busy;
      end else begin
         req_stall = in_range && (!s1_ready || hazard);
      end
   end

   assign take_item = req_valid && !req_stall && (req_data.action == ACTION_FILTER) && in_range;
   assign take_clear = req_valid && !req_stall && (req_data.action == ACTION_CLEAR);
   assign wb = s3_v_ff && out_free;

   assign rd_addr = AW'(req_data.chan);
   assign wr_addr = AW'(s3_chan_ff);

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= '0;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_fb1_ff <= '0;
         coef_fb2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_B0:    coef_b0_ff <= csr_wdata;
            CSR_COEF_B1_FF: coef_b1_ff <= csr_wdata;
            CSR_COEF_B2_FF: coef_b2_ff <= csr_wdata;
            CSR_COEF_FB1:   coef_fb1_ff <= csr_wdata;
            CSR_COEF_FB2:   coef_fb2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (wb) begin
         hist_mem[wr_addr] <= '{x1: s3_x_ff, x2: s3_x1_ff, y1: y_in, y2: s3_y1_ff};
      end
      if (take_item) begin
         rd_entry_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (take_clear) begin
            hist_valid_ff <= '0;
         end else if (wb) begin
            hist_valid_ff[wr_addr] <= 1'b1;
         end
         if (take_item) begin
            rd_valid_ff <= hist_valid_ff[rd_addr];
         end
      end
   end

   assign s1_x1 = rd_valid_ff ? rd_entry_ff.x1 : '0;
   assign s1_x2 = rd_valid_ff ? rd_entry_ff.x2 : '0;
   assign s1_y1 = rd_valid_ff ? rd_entry_ff.y1 : '0;
   assign s1_y2 = rd_valid_ff ? rd_entry_ff.y2 : '0;

   assign p0_in = coef_b0_ff * s1_x_ff;
   assign p1_in = coef_b1_ff * s1_x1;
   assign p2_in = coef_b2_ff * s1_x2;
   assign p3_in = coef_fb1_ff * s1_y1;
   assign p4_in = coef_fb2_ff * s1_y2;

   assign ff_sum_in = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff);
   assign fb_sum_in = ACC_W'(p3_ff) + ACC_W'(p4_ff);

   // round half up, then saturate
   assign total = ff_sum_ff - fb_sum_ff + ROUND_HALF;
   assign scaled = total[ACC_W-1:COEF_FRAC];

   always_comb begin
      if (scaled > SAT_HI) begin
         y_in = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else if (scaled < SAT_LO) begin
         y_in = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         y_in = scaled[SAMPLE_WIDTH-1:0];
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= take_item;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s3_v_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (take_item) begin
         s1_chan_ff <= req_data.chan;
         s1_x_ff <= req_data.sample_in;
      end
      if (s1_v_ff && s2_ready) begin
         s2_chan_ff <= s1_chan_ff;
         s2_x_ff <= s1_x_ff;
         s2_x1_ff <= s1_x1;
         s2_y1_ff <= s1_y1;
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         p4_ff <= p4_in;
      end
      if (s2_v_ff && s3_ready) begin
         s3_chan_ff <= s2_chan_ff;
         s3_x_ff <= s2_x_ff;
         s3_x1_ff <= s2_x1_ff;
         s3_y1_ff <= s2_y1_ff;
         ff_sum_ff <= ff_sum_in;
         fb_sum_ff <= fb_sum_in;
      end
      if (wb) begin
         rsp_data_ff.chan_out <= s3_chan_ff;
         rsp_data_ff.sample_out <= y_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // no two words of one channel in flight at once
   a_no_chan_overlap: assert property (@(posedge clock) disable iff (reset)
      !((s1_v_ff && s2_v_ff && (s1_chan_ff == s2_chan_ff)) ||
        (s1_v_ff && s3_v_ff && (s1_chan_ff == s3_chan_ff)) ||
        (s2_v_ff && s3_v_ff && (s2_chan_ff == s3_chan_ff))))
      else $error("two words of one channel in flight");

   // a clear is taken only with the pipeline drained
   a_clear_when_empty: assert property (@(posedge clock) disable iff (reset)
      take_clear |-> !busy)
      else $error("clear taken with words in flight");

   // a clear leaves every history reading as zero
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      take_clear |=> (hist_valid_ff == '0))
      else $error("history flags not cleared");

   // a result only appears after a word leaves the last stage
   a_rsp_from_s3: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s3_v_ff))
      else $error("result without a word in the last stage");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for the multichannel biquad filter: predictor, stimulus tasks and result checking.
module tb;
   import biq_pkg::*;

   localparam int NUM_CHANNELS = 8;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam logic [COEF_WIDTH-1:0] UNITY = COEF_WIDTH'(1) << COEF_FRAC;
   localparam logic [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [COEF_WIDTH-1:0] csr_wdata = '0;

   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;

   // filter state as the block should hold it
   logic signed [COEF_WIDTH-1:0] gain [5];
   logic signed [SAMPLE_WIDTH-1:0] x_hist1 [NUM_CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] x_hist2 [NUM_CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] y_hist1 [NUM_CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] y_hist2 [NUM_CHANNELS];

   rsp_word_type filtered_due [$];

   int mismatch_count = 0;
   int filtered_sent = 0;
   int clears_sent = 0;
   int settings_loaded = 0;
   int results_checked = 0;

   multichannel_biquad_filter_top #(
      .CHANNELS(NUM_CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Timeout at %0t with %0d words outstanding", $time, filtered_due.size());
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void clear_histories();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         x_hist1[c] = '0;
         x_hist2[c] = '0;
         y_hist1[c] = '0;
         y_hist2[c] = '0;
      end
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] biquad_output(
      input logic [CHAN_WIDTH-1:0] ch,
      input logic signed [SAMPLE_WIDTH-1:0] x
   );
      longint acc;
      longint y;
      acc = longint'(gain[CSR_COEF_B0]) * longint'(x)
          + longint'(gain[CSR_COEF_B1_FF]) * longint'(x_hist1[ch])
          + longint'(gain[CSR_COEF_B2_FF]) * longint'(x_hist2[ch])
          - longint'(gain[CSR_COEF_FB1]) * longint'(y_hist1[ch])
          - longint'(gain[CSR_COEF_FB2]) * longint'(y_hist2[ch]);
      y = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
      end
      if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
      end
      x_hist2[ch] = x_hist1[ch];
      x_hist1[ch] = x;
      y_hist2[ch] = y_hist1[ch];
      y_hist1[ch] = SAMPLE_WIDTH'(y);
      return SAMPLE_WIDTH'(y);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
      case ($urandom_range(9))
         0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
         2: return SAMPLE_WIDTH'(int'($urandom_range(512)) - 256);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   // roughly -0.5 .. +0.5
   function automatic logic [COEF_WIDTH-1:0] gentle_coef();
      return COEF_WIDTH'(int'($urandom_range(1 << 28)) - (1 << 27));
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) begin
         $display("ERROR at %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type due;
      results_checked++;
      if (filtered_due.size() == 0) begin
         report_mismatch($sformatf("unexpected word chan %0d sample %0d",
                                   got.chan_out, got.sample_out));
      end else begin
         due = filtered_due.pop_front();
         if (got.chan_out !== due.chan_out) begin
            report_mismatch($sformatf("chan_out %0d, expected %0d",
                                      got.chan_out, due.chan_out));
         end
         if (got.sample_out !== due.sample_out) begin
            report_mismatch($sformatf("chan %0d sample_out %0d, expected %0d",
                                      due.chan_out, got.sample_out, due.sample_out));
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= rsp_gaps && ($urandom_range(99) < 24);
   end

   // inputs only move at the rising edge, so the falling edge sees what the next edge takes
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_result(rsp_data);
      end
   end

   task automatic send_word(input req_word_type word);
      bit taken;
      rsp_word_type due;
      while (req_gaps && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      if (word.action == ACTION_CLEAR) begin
         clear_histories();
         clears_sent++;
      end else begin
         due.chan_out = word.chan;
         due.sample_out = biquad_output(word.chan, word.sample_in);
         filtered_due.push_back(due);
         filtered_sent++;
      end
   endtask

   task automatic filter_word(input int ch, input logic [SAMPLE_WIDTH-1:0] sample);
      req_word_type word;
      word.action = ACTION_FILTER;
      word.chan = CHAN_WIDTH'(ch);
      word.sample_in = sample;
      send_word(word);
   endtask

   task automatic clear_word();
      req_word_type word;
      word.action = ACTION_CLEAR;
      word.chan = CHAN_WIDTH'($urandom);
      word.sample_in = SAMPLE_WIDTH'($urandom);
      send_word(word);
   endtask

   // sender holds off until every result is back, then lets a clear drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (filtered_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(
      input logic [CSR_INDEX_WIDTH-1:0] idx,
      input logic [COEF_WIDTH-1:0] value
   );
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx <= CSR_COEF_FB2) begin
         gain[idx] = value;
      end
   endtask

   task automatic load_coefs(
      input logic [COEF_WIDTH-1:0] b0,
      input logic [COEF_WIDTH-1:0] b1,
      input logic [COEF_WIDTH-1:0] b2,
      input logic [COEF_WIDTH-1:0] f1,
      input logic [COEF_WIDTH-1:0] f2
   );
      write_reg(CSR_COEF_B0, b0);
      write_reg(CSR_COEF_B1_FF, b1);
      write_reg(CSR_COEF_B2_FF, b2);
      write_reg(CSR_COEF_FB1, f1);
      write_reg(CSR_COEF_FB2, f2);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_loaded++;
   endtask

   task automatic run_stream(input int count);
      req_word_type word;
      logic [CHAN_WIDTH-1:0] last_chan;
      last_chan = '0;
      for (int n = 0; n < count; n++) begin
         word.action = ($urandom_range(99) < 2) ? ACTION_CLEAR : ACTION_FILTER;
         // repeat a channel often to hit the same-channel hazard
         word.chan = ($urandom_range(99) < 30) ? last_chan
                                               : CHAN_WIDTH'($urandom_range(NUM_CHANNELS - 1));
         word.sample_in = rand_sample();
         last_chan = word.chan;
         send_word(word);
      end
   endtask

   task automatic test_passthrough();
      wait_idle();
      load_coefs(UNITY, '0, '0, '0, '0);
      filter_word(0, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      filter_word(1, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
      filter_word(2, '0);
      filter_word(3, '1);
      filter_word(4, SAMPLE_WIDTH'(1));
      filter_word(5, 24'h555555);
      filter_word(6, 24'hAAAAAA);
      filter_word(7, SAMPLE_WIDTH'($urandom));
      // half a unit rounds up
      wait_idle();
      load_coefs(UNITY >> 1, '0, '0, '0, '0);
      filter_word(0, SAMPLE_WIDTH'(1));
      filter_word(0, SAMPLE_WIDTH'(-1));
      filter_word(0, SAMPLE_WIDTH'(3));
      filter_word(0, SAMPLE_WIDTH'(-3));
   endtask

   task automatic test_history_and_clear();
      wait_idle();
      load_coefs(UNITY >> 1, UNITY >> 1, UNITY >> 2, -(UNITY >> 1), UNITY >> 2);
      filter_word(3, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      filter_word(3, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      filter_word(5, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
      filter_word(3, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      clear_word();
      filter_word(3, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      filter_word(5, SAMPLE_WIDTH'(1));
   endtask

   task automatic test_saturation();
      wait_idle();
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      // writes past the last coefficient must change nothing
      for (int i = int'(CSR_COEF_FB2) + 1; i < 2 ** CSR_INDEX_WIDTH; i++) begin
         write_reg(CSR_INDEX_WIDTH'(i), $urandom);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      filter_word(7, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      filter_word(7, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
      wait_idle();
      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      filter_word(7, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      filter_word(7, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
      filter_word(6, '0);
   endtask

   task automatic test_random_streams();
      wait_idle();
      load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
      run_stream(300);
      wait_idle();
      load_coefs(gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef());
      run_stream(350);
      // stable double pole at one half
      wait_idle();
      load_coefs(UNITY >> 3, UNITY >> 2, UNITY >> 3, -UNITY, UNITY >> 2);
      run_stream(350);
      wait_idle();
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      run_stream(100);
      wait_idle();
      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      run_stream(100);
      wait_idle();
      load_coefs(gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef());
      run_stream(200);
   endtask

   task automatic test_no_idle();
      wait_idle();
      load_coefs(gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef());
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_stream(300);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < 5; i++) begin
         gain[i] = '0;
      end
      clear_histories();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough();
      test_history_and_clear();
      test_saturation();
      test_random_streams();
      test_no_idle();
      wait_idle();
      $display("Covered %0d filtered words and %0d clears over %0d channels, %0d coefficient sets.",
               filtered_sent, clears_sent, NUM_CHANNELS, settings_loaded);
      $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
